[rtl/i2c_master_bit_sequencer_unit_assert.svh]
// Assertion macros for the checker file.
`ifndef I2C_MASTER_BIT_SEQUENCER_UNIT_ASSERT_SVH
`define I2C_MASTER_BIT_SEQUENCER_UNIT_ASSERT_SVH

// Same-cycle implication, held off while reset is asserted.
`define I2CMS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("i2cms assertion failed");

// Next-cycle implication, held off while reset is asserted.
`define I2CMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("i2cms assertion failed");

`endif

[rtl/i2cms_pkg.sv]
`default_nettype none

package i2cms_pkg;

	localparam int BITS_PER_BYTE = 8;
	localparam int BIT_IDX_W     = $clog2(BITS_PER_BYTE);
	localparam int QUEUE_DEPTH   = 2;

	typedef enum logic [2:0] {
		OP_START = 3'd0,
		OP_STOP  = 3'd1,
		OP_SEND  = 3'd2,
		OP_RECV  = 3'd3,
		OP_SACK  = 3'd4,
		OP_RACK  = 3'd5
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data_byte;
		logic       ack_out;
		logic [7:0] sda_line;
	} cmd_desc_t;

	typedef struct packed {
		logic      valid;
		cmd_desc_t desc;
	} queue_head_t;

endpackage

`default_nettype wire

[rtl/i2cms_queue.sv]
`default_nettype none

module i2cms_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire i2cms_pkg::cmd_desc_t push_desc,
	output      logic                full,
	input  wire logic                pop,
	output      i2cms_pkg::queue_head_t head
);
	import i2cms_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_desc_t        mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign do_push  = push && !full;
	assign do_pop   = pop && (count_q != '0);
	assign head.valid = (count_q != '0);
	assign head.desc  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/i2cms_front.sv]
`default_nettype none

module i2cms_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output      logic                in_stall,
	input  wire logic [2:0]          command,
	input  wire logic [7:0]          data_byte,
	input  wire logic                ack_out,
	input  wire logic [7:0]          sda_line,
	output      logic                push,
	output      i2cms_pkg::cmd_desc_t push_desc,
	input  wire logic                q_full
);
	import i2cms_pkg::*;

	logic      valid_s1;
	cmd_desc_t desc_s1;
	logic      accept;
	logic      known;
	op_t       op;

	// Decode the command; unknown codes are dropped here.
	always_comb begin
		known = 1'b1;
		op    = OP_START;
		unique case (command)
			3'd0:    op = OP_START;
			3'd1:    op = OP_STOP;
			3'd2:    op = OP_SEND;
			3'd3:    op = OP_RECV;
			3'd4:    op = OP_SACK;
			3'd5:    op = OP_RACK;
			default: known = 1'b0;
		endcase
	end

	assign push      = valid_s1 && !q_full;
	assign push_desc = desc_s1;
	assign in_stall  = valid_s1 && q_full;
	assign accept    = in_valid && !in_stall;

	always_ff @(posedge clk) begin
		if (accept) begin
			desc_s1.op        <= op;
			desc_s1.data_byte <= data_byte;
			desc_s1.ack_out   <= ack_out;
			desc_s1.sda_line  <= sda_line;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= known;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

endmodule

`default_nettype wire

[rtl/i2cms_back.sv]
`default_nettype none

module i2cms_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire i2cms_pkg::queue_head_t head,
	output      logic                 pop,
	output      logic                 out_valid,
	input  wire logic                 out_stall,
	output      logic                 scl_level,
	output      logic                 sda_level,
	output      logic [7:0]           read_value,
	output      logic                 last
);
	import i2cms_pkg::*;

	localparam logic [BIT_IDX_W-1:0] BIT_LAST = BIT_IDX_W'(BITS_PER_BYTE - 1);

	logic                 out_valid_q;
	logic                 scl_drv_q;
	logic                 sda_drv_q;
	logic [7:0]           read_value_q;
	logic                 last_q;
	logic [1:0]           step_q;
	logic [BIT_IDX_W-1:0] bit_q;

	logic                 load;
	logic                 scl_nxt;
	logic                 sda_nxt;
	logic                 is_last;
	logic [7:0]           value_nxt;
	logic [1:0]           step_nxt;
	logic [BIT_IDX_W-1:0] bit_nxt;

	assign load = head.valid && (!out_valid_q || !out_stall);
	assign pop  = load && is_last;

	// One pin update per step; bit_q walks the byte MSB first.
	always_comb begin
		scl_nxt   = scl_drv_q;
		sda_nxt   = sda_drv_q;
		is_last   = 1'b0;
		value_nxt = '0;
		step_nxt  = step_q + 2'd1;
		bit_nxt   = bit_q;
		unique case (head.desc.op)
			OP_START: begin
				case (step_q)
					2'd0:    scl_nxt = 1'b1;
					2'd1:    sda_nxt = 1'b1;
					2'd2:    sda_nxt = 1'b0;
					default: begin
						scl_nxt = 1'b0;
						is_last = 1'b1;
					end
				endcase
			end
			OP_STOP: begin
				case (step_q)
					2'd0:    sda_nxt = 1'b0;
					2'd1:    scl_nxt = 1'b1;
					default: begin
						sda_nxt = 1'b1;
						is_last = 1'b1;
					end
				endcase
			end
			OP_SEND: begin
				case (step_q)
					2'd0:    sda_nxt = head.desc.data_byte[BIT_LAST - bit_q];
					2'd1:    scl_nxt = 1'b1;
					default: begin
						scl_nxt  = 1'b0;
						is_last  = (bit_q == BIT_LAST);
						step_nxt = 2'd0;
						bit_nxt  = bit_q + 1'b1;
					end
				endcase
			end
			OP_RECV: begin
				case (step_q)
					2'd0:    sda_nxt = 1'b1;
					2'd1:    scl_nxt = 1'b1;
					default: begin
						// later bits skip the release step
						scl_nxt   = 1'b0;
						is_last   = (bit_q == BIT_LAST);
						value_nxt = head.desc.sda_line;
						step_nxt  = 2'd1;
						bit_nxt   = bit_q + 1'b1;
					end
				endcase
			end
			OP_SACK: begin
				case (step_q)
					2'd0:    sda_nxt = head.desc.ack_out;
					2'd1:    scl_nxt = 1'b1;
					default: begin
						scl_nxt = 1'b0;
						is_last = 1'b1;
					end
				endcase
			end
			OP_RACK: begin
				case (step_q)
					2'd0:    sda_nxt = 1'b1;
					2'd1:    scl_nxt = 1'b1;
					default: begin
						scl_nxt   = 1'b0;
						is_last   = 1'b1;
						value_nxt = {7'd0, head.desc.sda_line[7]};
					end
				endcase
			end
			default: begin
				is_last = 1'b1;
			end
		endcase
		if (is_last) begin
			step_nxt = 2'd0;
			bit_nxt  = '0;
		end else if (!(head.desc.op == OP_SEND || head.desc.op == OP_RECV)) begin
			bit_nxt = bit_q;
		end
		if (!is_last) begin
			value_nxt = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			read_value_q <= value_nxt;
			last_q       <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			scl_drv_q   <= 1'b1;
			sda_drv_q   <= 1'b1;
			step_q      <= 2'd0;
			bit_q       <= '0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			scl_drv_q   <= scl_nxt;
			sda_drv_q   <= sda_nxt;
			step_q      <= step_nxt;
			bit_q       <= bit_nxt;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign scl_level  = scl_drv_q;
	assign sda_level  = sda_drv_q;
	assign read_value = read_value_q;
	assign last       = last_q;

endmodule

`default_nettype wire

[rtl/i2c_master_bit_sequencer_unit.sv]
// I2C master bit sequencer.
// Input channel (in_valid / in_stall): one bus command per transfer with
// command, data_byte, ack_out and sda_line. Codes 6 and 7 are taken and
// dropped without any pin update.
// Output channel (out_valid / out_stall): one pin update per transfer with
// scl_level, sda_level, read_value and last; last marks the final update of
// a command and read_value carries the received byte or ack bit there.
// Path: the first update of a command passes the decode register at its
// transfer edge, then a queue write, then the output register; a full
// queue or an output stall can hold it between them.
// Throughput: the sequencer emits one update per cycle while a command waits
// and the output is not stalled; a command makes 4 updates for start, 3 stop,
// 24 send byte, 17 receive byte, 3 send or receive ack. The next command
// waits in a two-entry queue, so its updates follow with no gap.
// Reset: both lines read released (1), the queue and stages empty.
// Output stall: hold the current update; the sequencer freezes, the queue
// fills and then in_stall rises until the receiver takes transfers again.
`default_nettype none

module i2c_master_bit_sequencer_unit (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output      logic       in_stall,
	input  wire logic [2:0] command,
	input  wire logic [7:0] data_byte,
	input  wire logic       ack_out,
	input  wire logic [7:0] sda_line,
	output      logic       out_valid,
	input  wire logic       out_stall,
	output      logic       scl_level,
	output      logic       sda_level,
	output      logic [7:0] read_value,
	output      logic       last
);
	import i2cms_pkg::*;

	logic        push;
	cmd_desc_t   push_desc;
	logic        q_full;
	logic        pop;
	queue_head_t head;

	// Front: decode commands, drop unknown codes.
	i2cms_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.data_byte (data_byte),
		.ack_out   (ack_out),
		.sda_line  (sda_line),
		.push      (push),
		.push_desc (push_desc),
		.q_full    (q_full)
	);

	// Decouple decode from the sequencer so each can stall on its own.
	i2cms_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.full      (q_full),
		.pop       (pop),
		.head      (head)
	);

	// Back: walk each command's pin updates into the output register.
	i2cms_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.scl_level  (scl_level),
		.sda_level  (sda_level),
		.read_value (read_value),
		.last       (last)
	);

endmodule

`default_nettype wire

[rtl/i2cms_checker.sv]
`default_nettype none
`include "i2c_master_bit_sequencer_unit_assert.svh"

module i2cms_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic       scl_level,
	input wire logic       sda_level,
	input wire logic [7:0] read_value,
	input wire logic       last
);
	logic        prev_scl_q;
	logic        prev_sda_q;
	logic        taken;
	logic        both_moved;
	logic [10:0] out_word;

	assign taken      = out_valid && !out_stall;
	assign both_moved = (scl_level != prev_scl_q) && (sda_level != prev_sda_q);
	assign out_word   = {scl_level, sda_level, read_value, last};

	// Track pin levels of the last delivered update; both released after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_scl_q <= 1'b1;
			prev_sda_q <= 1'b1;
		end else if (taken) begin
			prev_scl_q <= scl_level;
			prev_sda_q <= sda_level;
		end
	end

	// Each update moves at most one pin.
	`I2CMS_ASSERT_NOW(a_one_pin, clk, arst_n, taken, !both_moved)

	// Read data shows only on the final update of a command.
	`I2CMS_ASSERT_NOW(a_value_on_last, clk, arst_n, out_valid && !last, read_value == 8'd0)

	// A stalled update holds.
	`I2CMS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_word))

	// Input stall rises only right after a transfer is taken.
	`I2CMS_ASSERT_NEXT(a_stall_after_take, clk, arst_n, !in_valid && !in_stall, !in_stall)

endmodule

bind i2c_master_bit_sequencer_unit i2cms_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.scl_level  (scl_level),
	.sda_level  (sda_level),
	.read_value (read_value),
	.last       (last)
);

`default_nettype wire

[dv/tb_i2c_master_bit_sequencer_unit.sv]
`timescale 1ns / 100ps

module tb_i2c_master_bit_sequencer_unit;
	import i2cms_pkg::*;

	// Codes outside the command set: the block takes them and makes no pin update.
	localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
	localparam logic [2:0] CMD_UNUSED_7 = 3'd7;

	localparam int RANDOM_CMDS = 260;
	localparam int TAIL_CMDS   = 40;   // final stretch with no idling on either side
	localparam int HOLD_AFTER  = 60;   // transfers accepted before the long output hold
	localparam int HOLD_CYCLES = 200;

	typedef struct {
		logic [2:0] cmd;
		logic [7:0] data;
		logic       ack;
		logic [7:0] line;
	} bus_cmd_t;

	typedef struct {
		logic       scl;
		logic       sda;
		logic [7:0] rval;
		logic       last;
	} pin_update_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid;
	logic       in_stall;
	logic [2:0] command;
	logic [7:0] data_byte;
	logic       ack_out;
	logic [7:0] sda_line;
	logic       out_valid;
	logic       out_stall;
	logic       scl_level;
	logic       sda_level;
	logic [7:0] read_value;
	logic       last;

	bus_cmd_t    cmds_pending[$];
	pin_update_t pin_seq_due[$];

	// Line levels as the sequencer last drove them.
	logic scl_now;
	logic sda_now;

	int  failures = 0;
	int  cmds_accepted = 0;
	int  src_gap = 0;
	int  rx_hold = 0;
	logic long_hold = 1'b0;

	i2c_master_bit_sequencer_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.data_byte  (data_byte),
		.ack_out    (ack_out),
		.sda_line   (sda_line),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.scl_level  (scl_level),
		.sda_level  (sda_level),
		.read_value (read_value),
		.last       (last)
	);

	always #4 clk = ~clk;

	// Idling comes and goes in windows of commands; the tail of the run has none.
	function automatic bit idle_window();
		int left;
		left = cmds_pending.size();
		return (left >= TAIL_CMDS) && ((left / 32) % 3 != 0);
	endfunction

	task automatic push_cmd(input logic [2:0] c, input logic [7:0] d, input logic a,
			input logic [7:0] l);
		bus_cmd_t item;
		item.cmd  = c;
		item.data = d;
		item.ack  = a;
		item.line = l;
		cmds_pending.push_back(item);
	endtask

	// Fill the unused fields with noise so every bit toggles.
	task automatic push_noisy(input logic [2:0] c);
		push_cmd(c, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
			8'($urandom_range(0, 255)));
	endtask

	task automatic drive_line(input logic scl, input logic sda);
		pin_update_t upd;
		scl_now  = scl;
		sda_now  = sda;
		upd.scl  = scl;
		upd.sda  = sda;
		upd.rval = 8'h00;
		upd.last = 1'b0;
		pin_seq_due.push_back(upd);
	endtask

	// Work out the pin updates one command makes and append them in bus order.
	task automatic compute_pin_sequence(input bus_cmd_t it);
		pin_update_t tail;
		logic [7:0]  got;
		int          n_prior;
		n_prior = pin_seq_due.size();
		got = 8'h00;
		case (it.cmd)
			OP_START: begin
				drive_line(1'b1, sda_now);
				drive_line(scl_now, 1'b1);
				drive_line(scl_now, 1'b0);
				drive_line(1'b0, sda_now);
			end
			OP_STOP: begin
				drive_line(scl_now, 1'b0);
				drive_line(1'b1, sda_now);
				drive_line(scl_now, 1'b1);
			end
			OP_SEND: begin
				for (int b = 7; b >= 0; b--) begin
					drive_line(scl_now, it.data[b]);
					drive_line(1'b1, sda_now);
					drive_line(1'b0, sda_now);
				end
			end
			OP_RECV: begin
				drive_line(scl_now, 1'b1);
				for (int b = 7; b >= 0; b--) begin
					drive_line(1'b1, sda_now);
					got[b] = it.line[b];
					drive_line(1'b0, sda_now);
				end
			end
			OP_SACK: begin
				drive_line(scl_now, it.ack);
				drive_line(1'b1, sda_now);
				drive_line(1'b0, sda_now);
			end
			OP_RACK: begin
				drive_line(scl_now, 1'b1);
				drive_line(1'b1, sda_now);
				got = {7'd0, it.line[7]};
				drive_line(1'b0, sda_now);
			end
			default: ;
		endcase
		// Tag the final update with last and the read result.
		if (pin_seq_due.size() > n_prior) begin
			tail = pin_seq_due.pop_back();
			tail.rval = got;
			tail.last = 1'b1;
			pin_seq_due.push_back(tail);
		end
	endtask

	task automatic check_update();
		pin_update_t want;
		if (pin_seq_due.size() == 0) begin
			$error("pin update with none expected: scl=%0d sda=%0d read=%0h last=%0d",
				scl_level, sda_level, read_value, last);
			failures++;
		end else begin
			want = pin_seq_due.pop_front();
			if (scl_level !== want.scl) begin
				$error("scl_level: expected %0d, got %0d", want.scl, scl_level);
				failures++;
			end
			if (sda_level !== want.sda) begin
				$error("sda_level: expected %0d, got %0d", want.sda, sda_level);
				failures++;
			end
			if (read_value !== want.rval) begin
				$error("read_value: expected %0h, got %0h", want.rval, read_value);
				failures++;
			end
			if (last !== want.last) begin
				$error("last: expected %0d, got %0d", want.last, last);
				failures++;
			end
		end
	endtask

	// Command driver: predict on each transfer, then offer the next command
	// unless a gap is running. Hold the payload while the block stalls.
	always @(posedge clk or negedge arst_n) begin
		bus_cmd_t item;
		if (!arst_n) begin
			in_valid  <= 1'b0;
			command   <= OP_START;
			data_byte <= 8'h00;
			ack_out   <= 1'b0;
			sda_line  <= 8'h00;
			scl_now   = 1'b1;
			sda_now   = 1'b1;
			src_gap   = 0;
		end else begin
			if (in_valid && !in_stall) begin
				item.cmd  = command;
				item.data = data_byte;
				item.ack  = ack_out;
				item.line = sda_line;
				compute_pin_sequence(item);
				cmds_accepted++;
			end
			if (!in_valid || !in_stall) begin
				if (src_gap > 0) begin
					src_gap--;
					in_valid <= 1'b0;
				end else if (cmds_pending.size() > 0) begin
					item = cmds_pending.pop_front();
					command   <= item.cmd;
					data_byte <= item.data;
					ack_out   <= item.ack;
					sda_line  <= item.line;
					in_valid  <= 1'b1;
					// Keep offering during the long hold so the block backs up.
					if (!long_hold && idle_window() && $urandom_range(0, 4) == 0)
						src_gap = $urandom_range(1, 15);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Pin update monitor: check each transfer, then pick the next stall level.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_hold = 0;
		end else begin
			if (out_valid && !out_stall)
				check_update();
			if (long_hold) begin
				out_stall <= 1'b1;
			end else if (rx_hold > 0) begin
				rx_hold--;
				out_stall <= 1'b1;
			end else if (idle_window() && $urandom_range(0, 7) == 0) begin
				rx_hold = $urandom_range(0, 14);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Long output hold once traffic is flowing: the queue fills and in_stall rises.
	initial begin
		while (cmds_accepted < HOLD_AFTER)
			@(posedge clk);
		long_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		long_hold <= 1'b0;
	end

	// Worst case is far below this: 24 updates per command, each behind a full stall burst.
	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		int n_bytes;
		bit reading;

		// Directed: every command, field extremes, repeated start and unused codes.
		push_cmd(OP_START, 8'h00, 1'b0, 8'h00);
		push_cmd(OP_SEND,  8'h00, 1'b1, 8'hFF);
		push_cmd(OP_RACK,  8'hFF, 1'b1, 8'h00);
		push_cmd(OP_SEND,  8'hFF, 1'b0, 8'h00);
		push_cmd(OP_RACK,  8'h00, 1'b0, 8'h80);
		push_cmd(OP_SEND,  8'hA5, 1'b0, 8'h7F);
		push_cmd(OP_RACK,  8'h00, 1'b0, 8'h7F);
		push_cmd(OP_START, 8'hFF, 1'b1, 8'hFF);
		push_cmd(OP_RECV,  8'hFF, 1'b1, 8'h00);
		push_cmd(OP_SACK,  8'h00, 1'b0, 8'h00);
		push_cmd(OP_RECV,  8'h00, 1'b0, 8'hFF);
		push_cmd(OP_SACK,  8'hFF, 1'b1, 8'hFF);
		push_cmd(OP_RECV,  8'h3C, 1'b0, 8'h5A);
		push_cmd(CMD_UNUSED_6, 8'hFF, 1'b1, 8'hFF);
		push_cmd(OP_SACK,  8'h00, 1'b1, 8'hA5);
		push_cmd(CMD_UNUSED_7, 8'h00, 1'b0, 8'h00);
		push_cmd(OP_STOP,  8'h5A, 1'b1, 8'h81);
		push_cmd(OP_STOP,  8'h00, 1'b0, 8'h00);
		push_cmd(OP_SACK,  8'h01, 1'b0, 8'h01);
		push_cmd(OP_START, 8'h00, 1'b0, 8'h00);
		push_cmd(OP_START, 8'h00, 1'b0, 8'h00);
		push_cmd(OP_STOP,  8'h00, 1'b0, 8'h00);

		// Random: mostly whole bus transactions, some loose noise commands.
		while (cmds_pending.size() < RANDOM_CMDS) begin
			if ($urandom_range(0, 9) < 8) begin
				push_noisy(OP_START);
				push_noisy(OP_SEND);
				push_noisy(OP_RACK);
				n_bytes = $urandom_range(1, 4);
				reading = 1'($urandom_range(0, 1));
				repeat (n_bytes) begin
					if (reading) begin
						push_noisy(OP_RECV);
						push_noisy(OP_SACK);
					end else begin
						push_noisy(OP_SEND);
						push_noisy(OP_RACK);
					end
				end
				// Leave the stop out now and then so the next start is a repeated start.
				if ($urandom_range(0, 3) != 0)
					push_noisy(OP_STOP);
			end else begin
				repeat ($urandom_range(1, 4))
					push_noisy(3'($urandom_range(0, 7)));
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: every command taken, every update seen, then idle slack.
		while (cmds_pending.size() != 0 || in_valid)
			@(posedge clk);
		while (pin_seq_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (failures == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
